// File: hw/rtl/sprite_sort_and_batch_defines.svh
// ----------------------------------------------------------------------------
// Sprite sort and batch: shared assertion macros
// Implication checks that are clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPRITE_SORT_AND_BATCH_DEFINES_SVH
`define SPRITE_SORT_AND_BATCH_DEFINES_SVH

// Same-cycle implication.
`define SSB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite sort: same-cycle check failed");

// Next-cycle implication.
`define SSB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite sort: next-cycle check failed");

`endif

// File: hw/rtl/ssb_pkg.sv
// ----------------------------------------------------------------------------
// Sprite sort and batch: package
// Field widths, sort mode codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ssb_pkg;

  localparam int MAX_SPRITES_DEF = 32;

  localparam int TEX_W   = 32;
  localparam int DEPTH_W = 32;
  localparam int IDX_O_W = 5;
  localparam int VOFF_W  = 8;
  localparam int MODE_W  = 2;
  localparam int IN_W    = TEX_W + DEPTH_W;
  localparam int OUT_W   = IDX_O_W + TEX_W + 3 * VOFF_W + 3;

  localparam logic [VOFF_W-1:0] VERTS_PER_SPRITE = VOFF_W'(6);

  localparam logic [MODE_W-1:0] MODE_DEPTH_DESC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEPTH_ASC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEX_ASC    = 2'd2;

  typedef struct packed {
    logic load;      // input item accepted
    logic rk_init;   // frame closes: restart rank and emit counters
    logic ki_rd;     // read the record being ranked
    logic j_start;   // latch its key, restart the compare sweep
    logic j_rd;      // read the next record of the sweep
    logic rank_wr;   // write the finished rank into the order store
    logic ord_rd;    // read the order store at the fetch position
    logic tex_rd;    // read the texture of the fetched record
    logic e_first;   // take the first fetched record as current
    logic e_step;    // emit current, fetched record becomes current
    logic e_final;   // emit current as the last result, empty the store
  } ssb_cmd_t;

  typedef struct packed {
    logic j_last;    // sweep address is the last stored record
    logic i_last;    // record being ranked is the last one
    logic f_zero;    // fetch position is the first one
    logic f_last;    // fetch position is the last one
    logic out_free;  // output register can take a result this cycle
  } ssb_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/sprite_sort_and_batch.sv
// ----------------------------------------------------------------------------
// Sprite sort and batch: top level
//
//   channel  dir  handshake             payload
//   cfg      in   cfg_wr_en             cfg_wr_data = sort_mode
//   in       in   in_tvalid/in_tready   in_tdata, in_tlast = last_sprite
//   out      out  out_tvalid/out_tready out_tdata, out_tlast = last_result
//
// Sprites load at one item per cycle. When the item with in_tlast closes a
// frame of n stored sprites, the input stalls while the stable sort counts
// ranks through the single read port of the sprite store and while the emit
// pass, which also waits out any output stall, sends the results.
// The final result sits in the output register while loading resumes.
// rst_n is synchronous and active low; it empties the store and sets the
// sort mode to depth descending.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_sort_and_batch #(
  parameter int MAX_SPRITES = ssb_pkg::MAX_SPRITES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ssb_pkg::MODE_W-1:0] cfg_wr_data,  // sort_mode
  input  wire logic                       in_tvalid,
  output      logic                       in_tready,
  // texture_id [31:0], sprite_depth [63:32]
  input  wire logic [ssb_pkg::IN_W-1:0]   in_tdata,
  input  wire logic                       in_tlast,
  output      logic                       out_tvalid,
  input  wire logic                       out_tready,
  // sprite_index [4:0], sprite_texture [36:5], vertex_offset [44:37],
  // batch_start [45], batch_end [46], batch_offset [54:47],
  // batch_vertices [62:55], dropped [63]
  output      logic [ssb_pkg::OUT_W-1:0]  out_tdata,
  output      logic                       out_tlast
);

  import ssb_pkg::*;

  ssb_cmd_t cmd;
  ssb_sts_t sts;

  ssb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssb_dp #(.MAX_SPRITES(MAX_SPRITES)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ssb_ram.sv
// ----------------------------------------------------------------------------
// Sprite sort and batch: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/ssb_ctrl.sv
// ----------------------------------------------------------------------------
// Sprite sort and batch: controller
// Sequences loading, the rank count of the stable sort and the emit pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic            in_tlast,
  output      logic            in_tready,
  input  wire ssb_pkg::ssb_sts_t sts,
  output      ssb_pkg::ssb_cmd_t cmd
);

  import ssb_pkg::*;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_RK_I   = 4'd1;
  localparam logic [3:0] S_RK_K   = 4'd2;
  localparam logic [3:0] S_RK_J   = 4'd3;
  localparam logic [3:0] S_RK_D   = 4'd4;
  localparam logic [3:0] S_RK_W   = 4'd5;
  localparam logic [3:0] S_E_ORD  = 4'd6;
  localparam logic [3:0] S_E_TEX  = 4'd7;
  localparam logic [3:0] S_E_GOT  = 4'd8;
  localparam logic [3:0] S_E_LAST = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_tready   = 1'b1;
        cmd.load    = in_tvalid;
        if (in_tvalid && in_tlast) begin
          cmd.rk_init = 1'b1;
          state_nxt   = S_RK_I;
        end
      end
      S_RK_I: begin
        cmd.ki_rd = 1'b1;
        state_nxt = S_RK_K;
      end
      S_RK_K: begin
        cmd.j_start = 1'b1;
        state_nxt   = S_RK_J;
      end
      S_RK_J: begin
        cmd.j_rd = 1'b1;
        if (sts.j_last) begin
          state_nxt = S_RK_D;
        end
      end
      // The compare of the last swept record lands in this cycle.
      S_RK_D: begin
        state_nxt = S_RK_W;
      end
      S_RK_W: begin
        cmd.rank_wr = 1'b1;
        state_nxt   = sts.i_last ? S_E_ORD : S_RK_I;
      end
      S_E_ORD: begin
        cmd.ord_rd = 1'b1;
        state_nxt  = S_E_TEX;
      end
      S_E_TEX: begin
        cmd.tex_rd = 1'b1;
        state_nxt  = S_E_GOT;
      end
      S_E_GOT: begin
        if (sts.f_zero) begin
          cmd.e_first = 1'b1;
          state_nxt   = sts.f_last ? S_E_LAST : S_E_ORD;
        end else if (sts.out_free) begin
          cmd.e_step = 1'b1;
          state_nxt  = sts.f_last ? S_E_LAST : S_E_ORD;
        end
      end
      S_E_LAST: begin
        if (sts.out_free) begin
          cmd.e_final = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ssb_dp.sv
// ----------------------------------------------------------------------------
// Sprite sort and batch: datapath
// Sprite and order stores, rank counter for the stable sort, batch tracking
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sprite_sort_and_batch_defines.svh"

module ssb_dp #(
  parameter int MAX_SPRITES = ssb_pkg::MAX_SPRITES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ssb_pkg::MODE_W-1:0] cfg_wr_data,
  input  wire logic [ssb_pkg::IN_W-1:0]   in_tdata,
  input  wire logic                       out_tready,
  output      logic                       out_tvalid,
  output      logic [ssb_pkg::OUT_W-1:0]  out_tdata,
  output      logic                       out_tlast,
  input  wire ssb_pkg::ssb_cmd_t          cmd,
  output      ssb_pkg::ssb_sts_t          sts
);

  import ssb_pkg::*;

  localparam int IDX_W = $clog2(MAX_SPRITES);
  localparam int CNT_W = $clog2(MAX_SPRITES + 1);

  function automatic logic [TEX_W-1:0] sort_key(logic [MODE_W-1:0] mode,
                                                logic [TEX_W-1:0] tex,
                                                logic [DEPTH_W-1:0] dep);
    logic [TEX_W-1:0] key;
    // Flipping the sign bit turns the signed depth order into unsigned order.
    if (mode == MODE_TEX_ASC) begin
      key = tex;
    end else begin
      key = {~dep[DEPTH_W-1], dep[DEPTH_W-2:0]};
    end
    return key;
  endfunction

  logic [MODE_W-1:0]  sort_mode_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;
  logic [IDX_W-1:0]   i_r;
  logic [IDX_W-1:0]   j_r;
  logic [IDX_W-1:0]   jd_r;
  logic               cmp_v_r;
  logic [IDX_W-1:0]   rank_r;
  logic [TEX_W-1:0]   key_i_r;
  logic [IDX_W-1:0]   f_r;
  logic [IDX_W-1:0]   cur_idx_r;
  logic [TEX_W-1:0]   cur_tex_r;
  logic               cur_start_r;
  logic [VOFF_W-1:0]  voff_r;
  logic [VOFF_W-1:0]  run_off_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_last_r;

  logic               full;
  logic [IDX_W-1:0]   last_pos;
  logic               sp_we;
  logic               sp_re;
  logic [IDX_W-1:0]   sp_raddr;
  logic [TEX_W-1:0]   tex_rdata;
  logic [DEPTH_W-1:0] dep_rdata;
  logic [IDX_W-1:0]   ord_rdata;
  logic [TEX_W-1:0]   key_j;
  logic               asc;
  logic               j_before;
  logic               emit;
  logic               emit_end;
  logic [VOFF_W-1:0]  voff_next;
  logic [VOFF_W-1:0]  bverts;
  logic               out_free;

  assign full     = (cnt_r == CNT_W'(MAX_SPRITES));
  assign last_pos = IDX_W'(cnt_r - CNT_W'(1));

  assign sp_we    = cmd.load && !full;
  assign sp_re    = cmd.ki_rd || cmd.j_rd || cmd.tex_rd;
  assign sp_raddr = cmd.ki_rd ? i_r : (cmd.j_rd ? j_r : ord_rdata);

  ssb_ram #(.WIDTH(TEX_W), .DEPTH(MAX_SPRITES)) u_tex_ram (
    .clk   (clk),
    .we    (sp_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_tdata[TEX_W-1:0]),
    .re    (sp_re),
    .raddr (sp_raddr),
    .rdata (tex_rdata)
  );

  ssb_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_SPRITES)) u_depth_ram (
    .clk   (clk),
    .we    (sp_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_tdata[IN_W-1:TEX_W]),
    .re    (sp_re),
    .raddr (sp_raddr),
    .rdata (dep_rdata)
  );

  ssb_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SPRITES)) u_order_ram (
    .clk   (clk),
    .we    (cmd.rank_wr),
    .waddr (rank_r),
    .wdata (i_r),
    .re    (cmd.ord_rd),
    .raddr (f_r),
    .rdata (ord_rdata)
  );

  // A record counts toward the rank of record i when it sorts strictly ahead
  // of it, or has an equal key and arrived earlier; this keeps the sort stable.
  assign asc      = (sort_mode_r == MODE_DEPTH_ASC) || (sort_mode_r == MODE_TEX_ASC);
  assign key_j    = sort_key(sort_mode_r, tex_rdata, dep_rdata);
  assign j_before = (asc ? (key_j < key_i_r) : (key_j > key_i_r)) ||
                    ((key_j == key_i_r) && (jd_r < i_r));

  assign emit      = cmd.e_step || cmd.e_final;
  assign emit_end  = cmd.e_final || (tex_rdata != cur_tex_r);
  assign voff_next = voff_r + VERTS_PER_SPRITE;
  assign bverts    = emit_end ? (voff_next - run_off_r) : '0;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_mode_r <= MODE_DEPTH_DESC;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sort_mode_r <= cfg_wr_data;
      end
      if (cmd.e_final) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.load) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      cmp_v_r <= cmd.j_rd;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rk_init) begin
      i_r <= '0;
      f_r <= '0;
    end
    if (cmd.rank_wr) begin
      i_r <= i_r + IDX_W'(1);
    end
    if (cmd.j_start) begin
      key_i_r <= sort_key(sort_mode_r, tex_rdata, dep_rdata);
      j_r     <= '0;
      rank_r  <= '0;
    end else if (cmp_v_r && j_before) begin
      rank_r <= rank_r + IDX_W'(1);
    end
    if (cmd.j_rd) begin
      j_r  <= j_r + IDX_W'(1);
      jd_r <= j_r;
    end

    if (cmd.e_first) begin
      cur_idx_r   <= ord_rdata;
      cur_tex_r   <= tex_rdata;
      cur_start_r <= 1'b1;
      voff_r      <= '0;
      run_off_r   <= '0;
      f_r         <= f_r + IDX_W'(1);
    end else if (cmd.e_step) begin
      cur_idx_r   <= ord_rdata;
      cur_tex_r   <= tex_rdata;
      cur_start_r <= emit_end;
      voff_r      <= voff_next;
      if (emit_end) begin
        run_off_r <= voff_next;
      end
      f_r <= f_r + IDX_W'(1);
    end

    if (emit) begin
      out_data_r <= {ovf_r, bverts, run_off_r, emit_end, cur_start_r, voff_r,
                     cur_tex_r, IDX_O_W'(cur_idx_r)};
      out_last_r <= cmd.e_final;
    end
  end

  assign sts.j_last   = (j_r == last_pos);
  assign sts.i_last   = (i_r == last_pos);
  assign sts.f_zero   = (f_r == '0);
  assign sts.f_last   = (f_r == last_pos);
  assign sts.out_free = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `SSB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_SPRITES))
  `SSB_ASSERT_IMP(a_ovf_full, ovf_r, full)
  `SSB_ASSERT_IMP(a_rank_bound, cmd.rank_wr, (CNT_W'(rank_r) < cnt_r))
  `SSB_ASSERT_NXT(a_final_out, cmd.e_final, out_valid_r && out_last_r && (cnt_r == '0))

endmodule

`default_nettype wire

// File: tb/sv/sprite_order_checker.sv
// ----------------------------------------------------------------------------
// Sprite sort and batch: result checker
// Watches the configuration port and both streams of the sprite sorter. It
// keeps its own copy of the sprite store and the sort mode. When a frame
// closes it ranks the stored sprites and queues the expected results. Each
// result leaving the block is compared field by field with the oldest one
// queued.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_order_checker #(
  parameter int CAPACITY = ssb_pkg::MAX_SPRITES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ssb_pkg::MODE_W-1:0] cfg_wr_data,
  input  wire logic                       in_tvalid,
  input  wire logic                       in_tready,
  input  wire logic [ssb_pkg::IN_W-1:0]   in_tdata,
  input  wire logic                       in_tlast,
  input  wire logic                       out_tvalid,
  input  wire logic                       out_tready,
  input  wire logic [ssb_pkg::OUT_W-1:0]  out_tdata,
  input  wire logic                       out_tlast,
  output int                              mismatches,
  output int                              results_due
);

  import ssb_pkg::*;

  // Same bit layout as out_tdata, highest field first.
  typedef struct packed {
    logic              dropped;
    logic [VOFF_W-1:0] batch_vertices;
    logic [VOFF_W-1:0] batch_offset;
    logic              batch_end;
    logic              batch_start;
    logic [VOFF_W-1:0] vertex_offset;
    logic [TEX_W-1:0]  sprite_texture;
    logic [IDX_O_W-1:0] sprite_index;
  } sprite_result_t;

  logic [TEX_W-1:0]          tex_mem [CAPACITY];
  logic signed [DEPTH_W-1:0] depth_mem [CAPACITY];
  int                        loaded;
  bit                        overflow;
  logic [MODE_W-1:0]         mode;
  sprite_result_t            due_q [$];
  bit                        due_last_q [$];

  // True when sprite a must be placed strictly ahead of sprite b.
  function automatic bit ranks_ahead(int a, int b);
    case (mode)
      MODE_DEPTH_ASC: return depth_mem[a] < depth_mem[b];
      MODE_TEX_ASC:   return tex_mem[a] < tex_mem[b];
      default:        return depth_mem[a] > depth_mem[b];
    endcase
  endfunction

  task automatic rank_and_queue_frame();
    int             order [CAPACITY];
    int             cur;
    int             j;
    int             run_start;
    bit             opens;
    bit             closes;
    bit             at_end;
    sprite_result_t r;
    for (int i = 0; i < loaded; i++) order[i] = i;
    // Insertion sort only moves a sprite past strictly lower-ranked ones,
    // so equal keys keep their arrival order.
    for (int i = 1; i < loaded; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && ranks_ahead(cur, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    run_start = 0;
    for (int k = 0; k < loaded; k++) begin
      opens = 1'b1;
      if (k > 0) opens = tex_mem[order[k-1]] != tex_mem[order[k]];
      closes = 1'b1;
      if (k + 1 < loaded) closes = tex_mem[order[k+1]] != tex_mem[order[k]];
      if (opens) run_start = k;
      r.sprite_index   = IDX_O_W'(order[k]);
      r.sprite_texture = tex_mem[order[k]];
      r.vertex_offset  = VOFF_W'(int'(VERTS_PER_SPRITE) * k);
      r.batch_start    = opens;
      r.batch_end      = closes;
      r.batch_offset   = VOFF_W'(int'(VERTS_PER_SPRITE) * run_start);
      r.batch_vertices = closes ? VOFF_W'(int'(VERTS_PER_SPRITE) * (k - run_start + 1))
                                : '0;
      r.dropped        = overflow;
      at_end           = (k + 1 == loaded);
      due_q.insert(due_q.size(), r);
      due_last_q.insert(due_last_q.size(), at_end);
    end
    loaded = 0;
    overflow = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sprite_result_t want;
    sprite_result_t got;
    if (!rst_n) begin
      loaded = 0;
      overflow = 1'b0;
      mode = MODE_DEPTH_DESC;
      due_q.delete();
      due_last_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) mode = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (due_q.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none, actual %0h", $time, out_tdata);
        end else begin
          want = due_q.pop_front();
          check_field("sprite_index", want.sprite_index, got.sprite_index);
          check_field("sprite_texture", want.sprite_texture, got.sprite_texture);
          check_field("vertex_offset", want.vertex_offset, got.vertex_offset);
          check_field("batch_start", want.batch_start, got.batch_start);
          check_field("batch_end", want.batch_end, got.batch_end);
          check_field("batch_offset", want.batch_offset, got.batch_offset);
          check_field("batch_vertices", want.batch_vertices, got.batch_vertices);
          check_field("dropped", want.dropped, got.dropped);
          check_field("last_result", due_last_q.pop_front(), out_tlast);
        end
      end
      if (in_tvalid && in_tready) begin
        if (loaded < CAPACITY) begin
          tex_mem[loaded]   = in_tdata[TEX_W-1:0];
          depth_mem[loaded] = in_tdata[IN_W-1:TEX_W];
          loaded++;
        end else begin
          overflow = 1'b1;
        end
        if (in_tlast) rank_and_queue_frame();
      end
    end
    results_due = due_q.size();
  end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Sprite sort and batch: testbench top
// Sends a short directed set of frames covering signed depth extremes, ties,
// every sort mode and a mode change inside an open frame, then random frames
// of mostly small size with a few that overflow the store. Both streams idle
// at random; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  import ssb_pkg::*;

  localparam int IDLE_LIMIT     = 6000;
  localparam int RANDOM_SPRITES = 100;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [MODE_W-1:0] cfg_wr_data = MODE_DEPTH_DESC;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;
  int                mismatches;
  int                results_due;
  bit                calm;
  int                out_stall;
  int                idle_cycles;
  int                sprites_sent;

  sprite_sort_and_batch u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  sprite_order_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .results_due(results_due)
  );

  always #2 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 4) == 0) out_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Starts and ends at a falling edge. The valid stays high when the next
  // item follows without a gap.
  task automatic drive_sprite(input logic [31:0] tex, input logic [31:0] depth,
                              input bit closes_frame);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {depth, tex};
    in_tlast  <= closes_frame;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sprites_sent++;
  endtask

  // The sort mode only changes once no results are due; a frame may still be open.
  task automatic write_mode(input logic [MODE_W-1:0] m);
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Small pools of textures and depths make batches and ties common.
  task automatic send_frame(input int len);
    logic [31:0] tex_pool [3];
    logic [31:0] depth_pool [3];
    logic [31:0] tex;
    logic [31:0] depth;
    foreach (tex_pool[i]) begin
      tex_pool[i]   = $urandom();
      depth_pool[i] = $urandom();
    end
    for (int i = 0; i < len; i++) begin
      tex   = ($urandom_range(0, 3) != 0) ? tex_pool[$urandom_range(0, 2)] : $urandom();
      depth = ($urandom_range(0, 1) != 0) ? depth_pool[$urandom_range(0, 2)] : $urandom();
      drive_sprite(tex, depth, i == len - 1);
    end
  endtask

  initial begin
    int len;
    int base;
    bit first;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A frame of one sprite under the mode left by reset.
    drive_sprite(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    // Signed depth extremes and a depth tie that must stay in arrival order.
    write_mode(MODE_DEPTH_DESC);
    drive_sprite(32'h0000_0000, 32'h0000_0000, 1'b0);
    drive_sprite(32'h0000_0000, 32'h8000_0000, 1'b0);
    drive_sprite(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    drive_sprite(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    write_mode(MODE_DEPTH_ASC);
    drive_sprite(32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
    drive_sprite(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    drive_sprite(32'h0000_0001, 32'h8000_0000, 1'b0);
    drive_sprite(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    drive_sprite(32'h0000_0001, 32'h0001_0000, 1'b1);
    // Texture order is unsigned; equal textures form one batch.
    write_mode(MODE_TEX_ASC);
    drive_sprite(32'h0000_0000, 32'h1234_5678, 1'b0);
    drive_sprite(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    drive_sprite(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    drive_sprite(32'h0000_0000, 32'h0000_0000, 1'b0);
    drive_sprite(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // The unused mode is written with a frame open; it sorts by depth descending.
    drive_sprite(32'h0000_00AA, 32'h0000_0001, 1'b0);
    drive_sprite(32'h0000_00BB, 32'h0002_0000, 1'b0);
    write_mode(MODE_UNUSED);
    drive_sprite(32'h0000_00AA, 32'hFFFF_0000, 1'b1);

    base = sprites_sent;
    first = 1'b1;
    while (sprites_sent - base < RANDOM_SPRITES) begin
      if ($urandom_range(0, 2) == 0) write_mode(MODE_W'($urandom_range(0, 3)));
      calm = ($urandom_range(0, 4) == 0);
      if (first) len = $urandom_range(33, 36);
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(28, 36);
      else len = $urandom_range(1, 8);
      send_frame(len);
      first = 1'b0;
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (results_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
